FILE: src/sfsc_pkg.sv
// sfsc_pkg: shared constants, register index codes and types of the SBUS frame decoder
// used by every module of the block; depends on nothing
`default_nettype none

package sfsc_pkg;

  // frame layout
  localparam int unsigned FrameBytes  = 23;
  localparam int unsigned FrameBits   = FrameBytes * 8;
  localparam int unsigned ChanWidth   = 11;
  localparam int unsigned NumPacked   = 16;
  localparam int unsigned FlagsLsb    = NumPacked * ChanWidth;
  localparam int unsigned Digital0Bit = FlagsLsb;
  localparam int unsigned Digital1Bit = FlagsLsb + 1;
  localparam int unsigned FailsafeBit = FlagsLsb + 3;
  localparam int unsigned SelWidth    = 5;
  localparam int unsigned PosWidth    = 5;

  localparam logic [7:0]          HeaderByte = 8'h0F;
  localparam logic [7:0]          EndByte    = 8'h00;
  localparam logic [PosWidth-1:0] PosFirst   = 5'd1;
  localparam logic [PosWidth-1:0] PosLast    = 5'd24;

  // channel thresholds
  localparam logic [ChanWidth-1:0] ChanFull     = 11'h7FF;
  localparam logic [ChanWidth-1:0] ArmLimit     = 11'd500;
  localparam logic [ChanWidth-1:0] CalThrustMin = 11'd1566;
  localparam logic [ChanWidth-1:0] CalPitchMin  = 11'd1693;
  localparam logic [ChanWidth-1:0] ThrustLow    = 11'd172;
  localparam logic [ChanWidth-1:0] ThrustHigh   = 11'd1812;
  localparam logic [ChanWidth-1:0] AxisCenter   = 11'd992;
  localparam logic [ChanWidth-1:0] AxisSpan     = 11'd820;
  localparam logic [ChanWidth-1:0] AxisDead     = 11'd20;
  localparam logic [ChanWidth-1:0] AxisOffset   = 11'd41;

  // scaling: gain of 127 is (x << 7) - x, division by reciprocal multiply
  localparam int unsigned GainShift  = 7;
  localparam int unsigned ProdWidth  = ChanWidth + GainShift;
  localparam int unsigned RecipWidth = 19;
  localparam int unsigned RecipShift = 29;
  localparam int unsigned CmdWidth   = 7;
  localparam int unsigned AxisWidth  = CmdWidth + 1;
  localparam logic [RecipWidth-1:0] ThrustRecip = 19'd327361;  // ceil(2^29 / 1640)
  localparam logic [RecipWidth-1:0] AxisRecip   = 19'd335755;  // ceil(2^29 / 1599)

  // configuration register indexes
  localparam int unsigned CfgIdxWidth = 3;
  typedef enum logic [CfgIdxWidth-1:0] {
    CfgArm    = 3'd0,
    CfgThrust = 3'd1,
    CfgRoll   = 3'd2,
    CfgPitch  = 3'd3,
    CfgYaw    = 3'd4
  } cfg_idx_e;

  typedef logic [ChanWidth-1:0] chan_t;

  typedef struct packed {
    logic [SelWidth-1:0] arm;
    logic [SelWidth-1:0] thrust;
    logic [SelWidth-1:0] roll;
    logic [SelWidth-1:0] pitch;
    logic [SelWidth-1:0] yaw;
  } sel_cfg_t;

  // completed frame from the byte collector
  typedef struct packed {
    logic                 done;
    logic [FrameBits-1:0] data;
  } frame_t;

  // selected channel values and flags of one good frame
  typedef struct packed {
    chan_t thrust;
    chan_t yaw;
    chan_t pitch;
    chan_t roll;
    logic  arm;
    logic  failsafe;
    logic  cal_req;
  } sel_t;

endpackage

`default_nettype wire

FILE: src/sfsc_frame_rx.sv
// sfsc_frame_rx: header hunt, byte position counter and frame shift register
// depends on sfsc_pkg
`default_nettype none

module sfsc_frame_rx (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  logic [7:0]     rx_byte_i,
  output sfsc_pkg::frame_t frame_o
);
  import sfsc_pkg::*;

  logic [PosWidth-1:0]  pos_q, pos_d;
  logic [FrameBits-1:0] frame_q, frame_d;
  logic                 done;

  // position tracking; data bytes shift in from the top so byte 1 ends at bit 0
  always_comb begin
    pos_d   = pos_q;
    frame_d = frame_q;
    done    = 1'b0;
    if (fire_i) begin
      priority if (pos_q == '0) begin
        if (rx_byte_i == HeaderByte) pos_d = PosFirst;
      end else if (pos_q < PosLast) begin
        frame_d = {rx_byte_i, frame_q[FrameBits-1:8]};
        pos_d   = pos_q + PosFirst;
      end else begin
        pos_d = '0;
        done  = (pos_q == PosLast) && (rx_byte_i == EndByte);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  // frame storage, no reset
  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
  end

  assign frame_o.done = done;
  assign frame_o.data = frame_q;

endmodule

`default_nettype wire

FILE: src/sfsc_select.sv
// sfsc_select: channel selection, arm decision and calibrate gesture state
// depends on sfsc_pkg
`default_nettype none

module sfsc_select (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfsc_pkg::frame_t   frame_i,
  input  sfsc_pkg::sel_cfg_t cfg_i,
  output logic               ready_o,
  output logic               valid_o,
  input  logic               ready_i,
  output sfsc_pkg::sel_t     sel_o
);
  import sfsc_pkg::*;

  // pick one decoded channel; unknown selects read as 0
  function automatic chan_t chan_pick(logic [FrameBits-1:0] f, logic [SelWidth-1:0] s);
    chan_t v;
    v = '0;
    for (int i = 0; i < NumPacked; i++) begin
      if (s == SelWidth'(i)) v = f[i*ChanWidth +: ChanWidth];
    end
    if (s == SelWidth'(NumPacked))     v = f[Digital0Bit] ? ChanFull : '0;
    if (s == SelWidth'(NumPacked + 1)) v = f[Digital1Bit] ? ChanFull : '0;
    return v;
  endfunction

  chan_t thr_c, yaw_c, pit_c, rol_c, arm_c;
  logic  arm, gesture;
  logic  calibrating_q, calibrating_d;
  logic  valid_q;
  sel_t  sel_q, sel_d;

  assign thr_c = chan_pick(frame_i.data, cfg_i.thrust);
  assign yaw_c = chan_pick(frame_i.data, cfg_i.yaw);
  assign pit_c = chan_pick(frame_i.data, cfg_i.pitch);
  assign rol_c = chan_pick(frame_i.data, cfg_i.roll);
  assign arm_c = chan_pick(frame_i.data, cfg_i.arm);

  // arm and calibrate gesture
  assign arm     = arm_c > ArmLimit;
  assign gesture = !arm && (thr_c >= CalThrustMin) && (pit_c >= CalPitchMin);
  assign calibrating_d = frame_i.done ? gesture : calibrating_q;

  always_comb begin
    sel_d.thrust   = thr_c;
    sel_d.yaw      = yaw_c;
    sel_d.pitch    = pit_c;
    sel_d.roll     = rol_c;
    sel_d.arm      = arm;
    sel_d.failsafe = frame_i.data[FailsafeBit];
    sel_d.cal_req  = gesture && !calibrating_q;
  end

  // stage handshake
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= 1'b0;
      calibrating_q <= 1'b0;
    end else begin
      calibrating_q <= calibrating_d;
      if (ready_o) valid_q <= frame_i.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && frame_i.done) sel_q <= sel_d;
  end

  assign valid_o = valid_q;
  assign sel_o   = sel_q;

endmodule

`default_nettype wire

FILE: src/sfsc_scale.sv
// sfsc_scale: two-stage scaling of thrust and axis channels into commands
// depends on sfsc_pkg; stage one forms x*127, stage two divides by reciprocal multiply
`default_nettype none

module sfsc_scale (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  sfsc_pkg::sel_t               sel_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [sfsc_pkg::CmdWidth-1:0] thrust_cmd_o,
  output logic [sfsc_pkg::AxisWidth-1:0] yaw_cmd_o,
  output logic [sfsc_pkg::AxisWidth-1:0] pitch_cmd_o,
  output logic [sfsc_pkg::AxisWidth-1:0] roll_cmd_o,
  output logic                         arm_flag_o,
  output logic                         failsafe_flag_o,
  output logic                         calibrate_request_o
);
  import sfsc_pkg::*;

  typedef struct packed {
    logic                 ok;
    logic                 neg;
    logic [ProdWidth-1:0] prod;
  } axis_pre_t;

  typedef struct packed {
    logic                 thr_ok;
    logic [ProdWidth-1:0] thr_prod;
    axis_pre_t            yaw;
    axis_pre_t            pitch;
    axis_pre_t            roll;
    logic                 arm;
    logic                 failsafe;
    logic                 cal_req;
  } pre_t;

  typedef struct packed {
    logic [CmdWidth-1:0]  thrust;
    logic [AxisWidth-1:0] yaw;
    logic [AxisWidth-1:0] pitch;
    logic [AxisWidth-1:0] roll;
    logic                 arm;
    logic                 failsafe;
    logic                 cal_req;
  } res_t;

  // deadband check, magnitude and (2|d| - 41) * 127
  function automatic axis_pre_t axis_pre(chan_t c);
    axis_pre_t r;
    chan_t     mag;
    chan_t     t;
    r.neg  = c < AxisCenter;
    mag    = r.neg ? (AxisCenter - c) : (c - AxisCenter);
    r.ok   = (mag > AxisDead) && (mag <= AxisSpan);
    t      = {mag[ChanWidth-2:0], 1'b0} - AxisOffset;
    r.prod = {t, {GainShift{1'b0}}} - ProdWidth'(t);
    return r;
  endfunction

  // floor(prod / d) as (prod * ceil(2^29 / d)) >> 29
  function automatic logic [CmdWidth-1:0] recip_div(logic [ProdWidth-1:0] p,
                                                    logic [RecipWidth-1:0] m);
    logic [ProdWidth+RecipWidth-1:0] full;
    full = (ProdWidth+RecipWidth)'(p) * (ProdWidth+RecipWidth)'(m);
    return full[RecipShift +: CmdWidth];
  endfunction

  function automatic logic [AxisWidth-1:0] axis_post(axis_pre_t a);
    logic [AxisWidth-1:0] mag;
    mag = a.ok ? {1'b0, recip_div(a.prod, AxisRecip)} : '0;
    return a.neg ? (~mag + AxisWidth'(1)) : mag;
  endfunction

  pre_t  pre_q, pre_d;
  res_t  res_q, res_d;
  logic  pre_valid_q, res_valid_q;
  logic  res_ready, pre_ready;
  chan_t thr_x;

  // stage one: offsets, range checks and gain
  assign thr_x = sel_i.thrust - ThrustLow;

  always_comb begin
    pre_d.thr_ok   = (sel_i.thrust >= ThrustLow) && (sel_i.thrust <= ThrustHigh);
    pre_d.thr_prod = {thr_x, {GainShift{1'b0}}} - ProdWidth'(thr_x);
    pre_d.yaw      = axis_pre(sel_i.yaw);
    pre_d.pitch    = axis_pre(sel_i.pitch);
    pre_d.roll     = axis_pre(sel_i.roll);
    pre_d.arm      = sel_i.arm;
    pre_d.failsafe = sel_i.failsafe;
    pre_d.cal_req  = sel_i.cal_req;
  end

  // stage two: division and sign
  always_comb begin
    res_d.thrust   = pre_q.thr_ok ? recip_div(pre_q.thr_prod, ThrustRecip) : '0;
    res_d.yaw      = axis_post(pre_q.yaw);
    res_d.pitch    = axis_post(pre_q.pitch);
    res_d.roll     = axis_post(pre_q.roll);
    res_d.arm      = pre_q.arm;
    res_d.failsafe = pre_q.failsafe;
    res_d.cal_req  = pre_q.cal_req;
  end

  // stage handshakes
  assign res_ready = !res_valid_q || ready_i;
  assign pre_ready = !pre_valid_q || res_ready;
  assign ready_o   = pre_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (pre_ready) pre_valid_q <= valid_i;
      if (res_ready) res_valid_q <= pre_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pre_ready && valid_i)     pre_q <= pre_d;
    if (res_ready && pre_valid_q) res_q <= res_d;
  end

  assign valid_o             = res_valid_q;
  assign thrust_cmd_o        = res_q.thrust;
  assign yaw_cmd_o           = res_q.yaw;
  assign pitch_cmd_o         = res_q.pitch;
  assign roll_cmd_o          = res_q.roll;
  assign arm_flag_o          = res_q.arm;
  assign failsafe_flag_o     = res_q.failsafe;
  assign calibrate_request_o = res_q.cal_req;

endmodule

`default_nettype wire

FILE: src/sbus_frame_to_stick_controls.sv
// sbus_frame_to_stick_controls: top level of the SBUS frame decoder
// depends on sfsc_pkg, sfsc_frame_rx, sfsc_select and sfsc_scale
//
//   channel | signals                                     | carries
//   --------+---------------------------------------------+------------------------------
//   in      | in_valid_i, in_ready_o, rx_byte_i           | one serial byte per item
//   out     | out_valid_o, out_ready_i, *_cmd_o, *_flag_o | stick commands of a good frame
//   cfg     | cfg_we_i, cfg_index_i, cfg_wdata_i          | channel select registers
//
// One byte is taken per cycle while in_ready_o is high; the header, data bytes and a bad
// end byte give no item. A good end byte yields an out item via select, gain and divide.
// Reset clears the byte position, the calibrate state and the select registers.
// A stalled output holds its item; bytes are still taken until the pipeline fills.
`default_nettype none

module sbus_frame_to_stick_controls (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        rx_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sfsc_pkg::CmdWidth-1:0]     thrust_cmd_o,
  output logic signed [sfsc_pkg::AxisWidth-1:0] yaw_cmd_o,
  output logic signed [sfsc_pkg::AxisWidth-1:0] pitch_cmd_o,
  output logic signed [sfsc_pkg::AxisWidth-1:0] roll_cmd_o,
  output logic                              arm_flag_o,
  output logic                              failsafe_flag_o,
  output logic                              calibrate_request_o,
  input  logic                              cfg_we_i,
  input  logic [sfsc_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [sfsc_pkg::SelWidth-1:0]     cfg_wdata_i
);
  import sfsc_pkg::*;

  sel_cfg_t cfg_q, cfg_d;
  frame_t   frame;
  sel_t     sel;
  logic     in_fire;
  logic     sel_valid, scale_ready;
  logic [AxisWidth-1:0] yaw_cmd, pitch_cmd, roll_cmd;

  // channel select registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgArm:    cfg_d.arm    = cfg_wdata_i;
        CfgThrust: cfg_d.thrust = cfg_wdata_i;
        CfgRoll:   cfg_d.roll   = cfg_wdata_i;
        CfgPitch:  cfg_d.pitch  = cfg_wdata_i;
        CfgYaw:    cfg_d.yaw    = cfg_wdata_i;
        default:   cfg_d        = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_fire = in_valid_i && in_ready_o;

  // byte collector
  sfsc_frame_rx u_frame_rx (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (in_fire),
    .rx_byte_i (rx_byte_i),
    .frame_o   (frame)
  );

  // channel select and gesture
  sfsc_select u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .frame_i (frame),
    .cfg_i   (cfg_q),
    .ready_o (in_ready_o),
    .valid_o (sel_valid),
    .ready_i (scale_ready),
    .sel_o   (sel)
  );

  // scaling pipeline and output register
  sfsc_scale u_scale (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .valid_i             (sel_valid),
    .ready_o             (scale_ready),
    .sel_i               (sel),
    .valid_o             (out_valid_o),
    .ready_i             (out_ready_i),
    .thrust_cmd_o        (thrust_cmd_o),
    .yaw_cmd_o           (yaw_cmd),
    .pitch_cmd_o         (pitch_cmd),
    .roll_cmd_o          (roll_cmd),
    .arm_flag_o          (arm_flag_o),
    .failsafe_flag_o     (failsafe_flag_o),
    .calibrate_request_o (calibrate_request_o)
  );

  assign yaw_cmd_o   = $signed(yaw_cmd);
  assign pitch_cmd_o = $signed(pitch_cmd);
  assign roll_cmd_o  = $signed(roll_cmd);

endmodule

`default_nettype wire

FILE: src/sfsc_checker.sv
// sfsc_checker: port-level assertions for sbus_frame_to_stick_controls
// depends on sfsc_pkg; attached to the top level by the bind at the end of this file
`default_nettype none

module sfsc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [sfsc_pkg::CmdWidth-1:0]     thrust_cmd_o,
  input logic signed [sfsc_pkg::AxisWidth-1:0] yaw_cmd_o,
  input logic signed [sfsc_pkg::AxisWidth-1:0] pitch_cmd_o,
  input logic signed [sfsc_pkg::AxisWidth-1:0] roll_cmd_o,
  input logic                              arm_flag_o,
  input logic                              calibrate_request_o
);

  logic out_fire;
  logic last_req_q;
  logic axis_min_seen;

  assign out_fire = out_valid_o && out_ready_i;
  assign axis_min_seen = (yaw_cmd_o == -8'sd128) || (pitch_cmd_o == -8'sd128) ||
                         (roll_cmd_o == -8'sd128);

  // calibrate request of the last delivered item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_req_q <= 1'b0;
    end else if (out_fire) begin
      last_req_q <= calibrate_request_o;
    end
  end

  // a stalled item holds its thrust and pitch commands and its calibrate request
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(thrust_cmd_o) &&
      $stable(pitch_cmd_o) && $stable(calibrate_request_o))
    else $error("output item changed while stalled");

  // an open output means the whole pipeline can move
  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output is ready");

  // calibration is only asked for while disarmed
  a_cal_disarmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && calibrate_request_o |-> !arm_flag_o)
    else $error("calibrate request while armed");

  // the request is a single pulse across delivered items
  a_cal_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && calibrate_request_o |-> !last_req_q)
    else $error("calibrate request on two items in a row");

  // axis commands stay symmetric within plus and minus 127
  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !axis_min_seen)
    else $error("axis command out of range");

endmodule

bind sbus_frame_to_stick_controls sfsc_checker u_sfsc_checker (.*);

`default_nettype wire

FILE: dv/tb_sbus_frame_to_stick_controls.sv
// tb_sbus_frame_to_stick_controls: self-checking testbench of the SBUS frame decoder
// streams header-framed byte sequences, predicts the stick commands of every good frame
// and matches them in order against the out channel; depends on sfsc_pkg and the RTL
`default_nettype none

module tb_sbus_frame_to_stick_controls;
  import sfsc_pkg::*;

  // one decoded command item
  typedef struct packed {
    logic [6:0]        thrust;
    logic signed [7:0] yaw;
    logic signed [7:0] pitch;
    logic signed [7:0] roll;
    logic              arm;
    logic              failsafe;
    logic              cal_req;
  } stick_cmd_t;

  // frame tracker: follows the byte stream and queues the commands each good frame yields
  class stick_cmd_model;
    logic [4:0]  sel_arm, sel_thrust, sel_roll, sel_pitch, sel_yaw;
    int unsigned pos;
    logic [7:0]  frame [23];
    bit          calibrating;
    stick_cmd_t  cmds_due [$];
    int unsigned errors;

    function new();
      sel_arm = '0; sel_thrust = '0; sel_roll = '0; sel_pitch = '0; sel_yaw = '0;
      pos = 0;
      calibrating = 1'b0;
      errors = 0;
      foreach (frame[i]) frame[i] = '0;
    endfunction

    function void set_select(cfg_idx_e idx, logic [4:0] v);
      case (idx)
        CfgArm:    sel_arm = v;
        CfgThrust: sel_thrust = v;
        CfgRoll:   sel_roll = v;
        CfgPitch:  sel_pitch = v;
        CfgYaw:    sel_yaw = v;
        default: ;
      endcase
    endfunction

    // 16 packed channels, then two digital ones from the flags byte
    function logic [10:0] chan(logic [4:0] s);
      logic [175:0] bits;
      for (int k = 0; k < 22; k++) bits[k*8 +: 8] = frame[k];
      if (s < 16) return bits[s*11 +: 11];
      if (s == 16) return frame[22][0] ? 11'h7FF : 11'h000;
      if (s == 17) return frame[22][1] ? 11'h7FF : 11'h000;
      return 11'h000;
    endfunction

    function logic [6:0] scale_thrust(int c);
      if (c < 172 || c > 1812) return 7'd0;
      return 7'(((c - 172) * 127) / 1640);
    endfunction

    // deadband around center, then rescale to +-127
    function logic signed [7:0] scale_axis(int c);
      int d, mag, v;
      d = c - 992;
      mag = (d < 0) ? -d : d;
      if (mag > 820 || mag <= 20) return 8'sd0;
      v = ((2 * mag - 41) * 127) / 1599;
      if (v > 127) v = 127;
      return (d < 0) ? 8'(-v) : 8'(v);
    endfunction

    function void take_byte(logic [7:0] b);
      logic [10:0] tc, pc;
      bit          armed, gesture;
      stick_cmd_t  c;
      if (pos == 0) begin
        if (b == HeaderByte) pos = 1;
        return;
      end
      if (pos < 24) begin
        frame[pos-1] = b;
        pos++;
        return;
      end
      pos = 0;
      if (b != EndByte) return;
      tc = chan(sel_thrust);
      pc = chan(sel_pitch);
      armed = chan(sel_arm) > 11'd500;
      gesture = !armed && tc >= 11'd1566 && pc >= 11'd1693;
      c.cal_req = 1'b0;
      // request fires once on entry to the gesture
      if (gesture) begin
        if (!calibrating) begin
          calibrating = 1'b1;
          c.cal_req = 1'b1;
        end
      end else begin
        calibrating = 1'b0;
      end
      c.thrust = scale_thrust(tc);
      c.yaw = scale_axis(chan(sel_yaw));
      c.pitch = scale_axis(pc);
      c.roll = scale_axis(chan(sel_roll));
      c.arm = armed;
      c.failsafe = frame[22][3];
      cmds_due.push_back(c);
    endfunction

    function void match_cmd(stick_cmd_t got);
      stick_cmd_t want;
      if (cmds_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected command item: thrust %0d yaw %0d", got.thrust,
                                   got.yaw);
        return;
      end
      want = cmds_due.pop_front();
      if (got.thrust !== want.thrust || got.yaw !== want.yaw || got.pitch !== want.pitch ||
          got.roll !== want.roll || got.arm !== want.arm || got.failsafe !== want.failsafe ||
          got.cal_req !== want.cal_req) begin
        errors++;
        if (errors <= 10) begin
          $display("cmd mismatch exp thr %0d yaw %0d pit %0d rol %0d arm %b fs %b cal %b",
                   want.thrust, want.yaw, want.pitch, want.roll, want.arm, want.failsafe,
                   want.cal_req);
          $display("             got thr %0d yaw %0d pit %0d rol %0d arm %b fs %b cal %b",
                   got.thrust, got.yaw, got.pitch, got.roll, got.arm, got.failsafe,
                   got.cal_req);
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        rx_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [6:0]        thrust_cmd;
  logic signed [7:0] yaw_cmd, pitch_cmd, roll_cmd;
  logic              arm_flag, failsafe_flag, calibrate_request;
  logic              cfg_we = 1'b0;
  logic [2:0]        cfg_index = '0;
  logic [4:0]        cfg_wdata = '0;

  stick_cmd_model book;
  bit          tx_idle_en = 1'b0;
  bit          rx_idle_en = 1'b0;
  bit          hold_off_req = 1'b0;
  bit          gesture_on = 1'b0;
  logic [10:0] chan_vals [16];
  logic [7:0]  frame_flags;
  int          chan_marks [16] = '{0, 171, 172, 173, 500, 501, 971, 972, 1012, 1013, 1566,
                                   1692, 1693, 1812, 1813, 2047};

  sbus_frame_to_stick_controls i_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .rx_byte_i           (rx_byte),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .thrust_cmd_o        (thrust_cmd),
    .yaw_cmd_o           (yaw_cmd),
    .pitch_cmd_o         (pitch_cmd),
    .roll_cmd_o          (roll_cmd),
    .arm_flag_o          (arm_flag),
    .failsafe_flag_o     (failsafe_flag),
    .calibrate_request_o (calibrate_request),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_wdata_i         (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

  // out side: ready runs, random stalls and one long hold-off on request
  initial begin
    wait (rst_n);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (rx_idle_en && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // out channel monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      book.match_cmd(stick_cmd_t'{thrust_cmd, yaw_cmd, pitch_cmd, roll_cmd, arm_flag,
                                  failsafe_flag, calibrate_request});
    end
  end

  task automatic send_byte(logic [7:0] b);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    book.take_byte(b);
  endtask

  task automatic send_frame(logic [7:0] flags, logic [7:0] tail);
    logic [175:0] packed_bits;
    for (int i = 0; i < 16; i++) packed_bits[i*11 +: 11] = chan_vals[i];
    send_byte(HeaderByte);
    for (int k = 0; k < 22; k++) send_byte(packed_bits[k*8 +: 8]);
    send_byte(flags);
    send_byte(tail);
  endtask

  task automatic write_select(cfg_idx_e idx, logic [4:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    book.set_select(idx, v);
  endtask

  task automatic load_selects(logic [4:0] a, logic [4:0] t, logic [4:0] r, logic [4:0] p,
                              logic [4:0] y);
    write_select(CfgArm, a);
    write_select(CfgThrust, t);
    write_select(CfgRoll, r);
    write_select(CfgPitch, p);
    write_select(CfgYaw, y);
    cfg_we <= 1'b0;
  endtask

  // wait for every queued command, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (book.cmds_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic stage_sticks(int c0, int c1, int c2, int c3, logic [7:0] flags);
    foreach (chan_vals[i]) chan_vals[i] = 11'd0;
    chan_vals[0] = 11'(c0);
    chan_vals[1] = 11'(c1);
    chan_vals[2] = 11'(c2);
    chan_vals[3] = 11'(c3);
    frame_flags = flags;
  endtask

  function automatic logic [10:0] pick_chan();
    case ($urandom_range(0, 5))
      0: return 11'($urandom_range(0, 2047));
      1: return 11'($urandom_range(172, 1812));
      2: return 11'($urandom_range(962, 1022));
      3: return 11'(chan_marks[$urandom_range(0, 15)]);
      4: return 11'($urandom_range(1500, 2047));
      default: return 11'($urandom_range(0, 600));
    endcase
  endfunction

  // force one selected channel toward a value, digital channels by threshold
  function automatic void put_chan(logic [4:0] s, int v);
    if (s < 16) chan_vals[s] = 11'(v);
    else if (s == 16) frame_flags[0] = (v >= 1024);
    else if (s == 17) frame_flags[1] = (v >= 1024);
  endfunction

  // random sticks, with runs of the calibrate gesture
  function automatic void randomize_frame();
    foreach (chan_vals[i]) chan_vals[i] = pick_chan();
    frame_flags = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) gesture_on = !gesture_on;
    if (gesture_on) begin
      put_chan(book.sel_thrust, $urandom_range(1566, 2047));
      put_chan(book.sel_pitch, $urandom_range(1693, 2047));
      put_chan(book.sel_arm, $urandom_range(0, 500));
    end
  endfunction

  function automatic logic [4:0] rand_sel();
    return ($urandom_range(0, 5) == 0) ? 5'($urandom_range(18, 31)) : 5'($urandom_range(0, 17));
  endfunction

  // good frames mostly, plus bad end bytes, line noise and cut-off frames
  task automatic random_unit();
    case ($urandom_range(0, 9))
      0: begin
        randomize_frame();
        send_frame(frame_flags, 8'($urandom_range(1, 255)));
      end
      1: repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
      2: begin
        send_byte(HeaderByte);
        repeat ($urandom_range(1, 23)) send_byte(8'($urandom_range(0, 255)));
      end
      default: begin
        randomize_frame();
        send_frame(frame_flags, EndByte);
      end
    endcase
  endtask

  initial begin
    book = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: scaling edges, flags, calibrate gesture
    load_selects(5'd16, 5'd0, 5'd1, 5'd2, 5'd3);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_byte(8'h00);
    send_byte(8'hF0);
    stage_sticks(172, 171, 172, 1812, 8'h00);
    send_frame(frame_flags, EndByte);
    stage_sticks(1812, 1813, 972, 1012, 8'h08);
    send_frame(frame_flags, EndByte);
    stage_sticks(1813, 971, 1013, 2047, 8'h01);
    send_frame(frame_flags, EndByte);
    stage_sticks(1566, 992, 1693, 0, 8'h00);
    send_frame(frame_flags, EndByte);
    send_frame(frame_flags, EndByte);
    // bad end byte leaves the gesture state alone
    send_frame(frame_flags, 8'hFF);
    send_frame(frame_flags, EndByte);
    stage_sticks(1566, 992, 1692, 0, 8'h00);
    send_frame(frame_flags, EndByte);
    stage_sticks(2047, 992, 2047, 0, 8'h00);
    send_frame(frame_flags, EndByte);
    stage_sticks(2047, 992, 2047, 0, 8'h01);
    send_frame(frame_flags, EndByte);
    drain();

    // selects past the last channel read as zero; roll selects digital channel 17
    load_selects(5'd31, 5'd18, 5'd17, 5'd31, 5'd20);
    stage_sticks(1000, 1500, 600, 1800, 8'h03);
    send_frame(frame_flags, EndByte);
    drain();

    // arm threshold on a packed channel
    load_selects(5'd5, 5'd3, 5'd2, 5'd1, 5'd0);
    stage_sticks(300, 1800, 1700, 1600, 8'h00);
    chan_vals[5] = 11'd500;
    send_frame(frame_flags, EndByte);
    chan_vals[5] = 11'd501;
    send_frame(frame_flags, EndByte);
    drain();

    // random phases, each with its own select setting
    for (int p = 0; p < 7; p++) begin
      case (p)
        1: load_selects(5'd17, 5'd17, 5'd17, 5'd17, 5'd17);
        2: load_selects(5'd0, 5'd0, 5'd0, 5'd0, 5'd0);
        default: load_selects(rand_sel(), rand_sel(), rand_sel(), rand_sel(), rand_sel());
      endcase
      tx_idle_en = (p != 6);
      rx_idle_en = (p != 6);
      // long out stall while bytes keep coming back to back
      if (p == 3) begin
        hold_off_req = 1'b1;
        tx_idle_en = 1'b0;
      end
      repeat (8) random_unit();
      drain();
    end

    if (book.errors == 0 && book.cmds_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
src/sfsc_pkg.sv
src/sfsc_frame_rx.sv
src/sfsc_select.sv
src/sfsc_scale.sv
src/sbus_frame_to_stick_controls.sv
src/sfsc_checker.sv
dv/tb_sbus_frame_to_stick_controls.sv
